[hw/rtl/binary_lifting_lca_macros.svh]
// Assertion macros shared by the lowest-common-ancestor block
`ifndef BINARY_LIFTING_LCA_MACROS_SVH
`define BINARY_LIFTING_LCA_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BLCA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define BLCA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/blca_pkg.sv]
// Types, constants and request codes of the lowest-common-ancestor block
package blca_pkg;

   localparam int NodeW    = 10;
   localparam int LevelW   = 4;
   localparam int DepthW   = 11;
   localparam int AddrW    = LevelW + NodeW;
   localparam int NumNodes = 1 << NodeW;
   localparam int NumEntries = 1 << AddrW;

   localparam logic [LevelW-1:0] TopLevel = LevelW'(15);
   localparam logic [DepthW-1:0] DepthMax = DepthW'(2047);

   typedef logic [NodeW-1:0]  node_type;
   typedef logic [LevelW-1:0] level_type;
   typedef logic [DepthW-1:0] depth_type;
   typedef logic [AddrW-1:0]  addr_type;

   typedef enum logic [1:0] {
      REQ_SET   = 2'd0,
      REQ_BUILD = 2'd1,
      REQ_QUERY = 2'd2,
      REQ_CLEAR = 2'd3
   } req_code_type;

   typedef enum logic [20:0] {
      S_CLEAR    = 21'h000001,
      S_IDLE     = 21'h000002,
      S_ZDEP     = 21'h000004,
      S_ROOT_RD  = 21'h000008,
      S_ROOT_CHK = 21'h000010,
      S_DEP_RD   = 21'h000020,
      S_DEP_CHK  = 21'h000040,
      S_DEP_PAR  = 21'h000080,
      S_DBL_RD1  = 21'h000100,
      S_DBL_RD2  = 21'h000200,
      S_DBL_WR   = 21'h000400,
      S_QA       = 21'h000800,
      S_QB       = 21'h001000,
      S_QC       = 21'h002000,
      S_L1_RD    = 21'h004000,
      S_L1_DEP   = 21'h008000,
      S_L1_CHK   = 21'h010000,
      S_L2_RD    = 21'h020000,
      S_L2_CHK   = 21'h040000,
      S_FIN_RD   = 21'h080000,
      S_FIN      = 21'h100000
   } state_type;

endpackage

[hw/rtl/binary_lifting_lca.sv]
// Lowest common ancestor by binary lifting: top level with sequencer and stores
// The block keeps a parent table of up to 1023 nodes plus 15 doubling levels in
// one 16384-entry ancestor memory (two read ports, one write port) and a
// 1024-entry depth memory. After reset, and after every clear request, a
// clearing pass writes zero to all 16384 ancestor entries, one per cycle, and
// to the 1024 depth entries, and the request channel is not ready until it
// ends. A parent write is taken in the idle state and leaves the channel
// ready. A query fetches both depths, then lifts over the 16 levels by depth
// (ancestor read, depth read, compare), then jointly over the 16 levels
// (paired ancestor read, compare), and finishes with a parent read; it holds
// there until the response register is free. A build zeroes the depths,
// scans for the root, runs depth passes over the nodes until nothing changes
// (up to the tree height) and fills each of the 15 doubling levels node by
// node, all over the memory ports. Only queries return a response.
module binary_lifting_lca (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_type,
   input  logic [blca_pkg::NodeW-1:0] req_node_a,
   input  logic [blca_pkg::NodeW-1:0] req_node_b,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [blca_pkg::NodeW-1:0] rsp_ancestor,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [blca_pkg::NodeW-1:0] csr_node_count
);
   import blca_pkg::*;

`include "binary_lifting_lca_macros.svh"

   // memories
   node_type  anc_mem [NumEntries];
   depth_type dep_mem [NumNodes];

   // sequencer state
   state_type state_ff, state_in;
   addr_type  cnt_ff, cnt_in;
   node_type  node_ff, node_in;
   level_type lvl_ff, lvl_in;
   node_type  u_ff, u_in, v_ff, v_in, tmp_ff, tmp_in;
   depth_type du_ff, du_in, dv_ff, dv_in;
   logic      chg_ff, chg_in;
   node_type  count_ff, count_in;
   logic      rsp_valid_ff, rsp_valid_in;
   node_type  rsp_anc_ff, rsp_anc_in;

   // memory ports
   addr_type  ax_addr, ay_addr, aw_addr;
   node_type  ax_rd_ff, ay_rd_ff, aw_data;
   logic      aw_en;
   node_type  dr_addr, dw_addr;
   depth_type dep_rd_ff, dw_data;
   logic      dw_en;

   logic      req_fire;
   level_type lvl_dn;
   depth_type dep_inc;
   logic      last_node;
   logic      par_chg;

   assign req_ready    = (state_ff == S_IDLE);
   assign req_fire     = req_valid && req_ready;
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ancestor = rsp_anc_ff;
   assign lvl_dn       = lvl_ff - LevelW'(1);
   assign dep_inc      = (dep_rd_ff == DepthMax) ? DepthMax : dep_rd_ff + DepthW'(1);
   assign last_node    = (node_ff == count_ff);
   assign par_chg      = (dep_rd_ff != '0);

   // sequence build, query and clear work over the memory ports
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      node_in      = node_ff;
      lvl_in       = lvl_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      tmp_in       = tmp_ff;
      du_in        = du_ff;
      dv_in        = dv_ff;
      chg_in       = chg_ff;
      count_in     = csr_valid ? csr_node_count : count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_anc_in   = rsp_anc_ff;
      ax_addr      = {LevelW'(0), node_ff};
      ay_addr      = {LevelW'(0), v_ff};
      aw_addr      = cnt_ff;
      aw_data      = '0;
      aw_en        = 1'b0;
      dr_addr      = node_ff;
      dw_addr      = cnt_ff[NodeW-1:0];
      dw_data      = '0;
      dw_en        = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            aw_en = 1'b1;
            dw_en = (cnt_ff[AddrW-1:NodeW] == '0);
            cnt_in = cnt_ff + AddrW'(1);
            if (&cnt_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               case (req_code_type'(req_type))
                  REQ_SET: begin
                     aw_addr = {LevelW'(0), req_node_a};
                     aw_data = req_node_b;
                     aw_en   = (req_node_a != '0);
                  end
                  REQ_BUILD: begin
                     cnt_in   = '0;
                     state_in = S_ZDEP;
                  end
                  REQ_QUERY: begin
                     u_in     = req_node_a;
                     v_in     = req_node_b;
                     state_in = S_QA;
                  end
                  REQ_CLEAR: begin
                     cnt_in   = '0;
                     state_in = S_CLEAR;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         // zero every depth before the build
         S_ZDEP: begin
            dw_en  = 1'b1;
            cnt_in = cnt_ff + AddrW'(1);
            if (&cnt_ff[NodeW-1:0]) begin
               node_in  = NodeW'(1);
               state_in = (count_ff == '0) ? S_IDLE : S_ROOT_RD;
            end
         end
         // find the first node without a parent
         S_ROOT_RD: begin
            state_in = S_ROOT_CHK;
         end
         S_ROOT_CHK: begin
            if (ax_rd_ff == '0 || last_node) begin
               if (ax_rd_ff == '0) begin
                  aw_addr = {LevelW'(0), node_ff};
                  aw_data = node_ff;
                  aw_en   = 1'b1;
                  dw_addr = node_ff;
                  dw_data = DepthW'(1);
                  dw_en   = 1'b1;
               end
               node_in  = NodeW'(1);
               chg_in   = 1'b0;
               state_in = S_DEP_RD;
            end else begin
               node_in  = node_ff + NodeW'(1);
               state_in = S_ROOT_RD;
            end
         end
         // propagate depths one pass at a time
         S_DEP_RD: begin
            state_in = S_DEP_CHK;
         end
         S_DEP_CHK: begin
            if (dep_rd_ff != '0) begin
               if (!last_node) begin
                  node_in  = node_ff + NodeW'(1);
                  state_in = S_DEP_RD;
               end else if (chg_ff) begin
                  node_in  = NodeW'(1);
                  chg_in   = 1'b0;
                  state_in = S_DEP_RD;
               end else begin
                  node_in  = NodeW'(1);
                  lvl_in   = LevelW'(1);
                  state_in = S_DBL_RD1;
               end
            end else begin
               dr_addr  = ax_rd_ff;
               state_in = S_DEP_PAR;
            end
         end
         S_DEP_PAR: begin
            if (par_chg) begin
               dw_addr = node_ff;
               dw_data = dep_inc;
               dw_en   = 1'b1;
            end
            if (!last_node) begin
               chg_in   = chg_ff || par_chg;
               node_in  = node_ff + NodeW'(1);
               state_in = S_DEP_RD;
            end else if (chg_ff || par_chg) begin
               node_in  = NodeW'(1);
               chg_in   = 1'b0;
               state_in = S_DEP_RD;
            end else begin
               node_in  = NodeW'(1);
               lvl_in   = LevelW'(1);
               state_in = S_DBL_RD1;
            end
         end
         // fill each level from two reads of the level below
         S_DBL_RD1: begin
            ax_addr  = {lvl_dn, node_ff};
            state_in = S_DBL_RD2;
         end
         S_DBL_RD2: begin
            ax_addr  = {lvl_dn, ax_rd_ff};
            state_in = S_DBL_WR;
         end
         S_DBL_WR: begin
            aw_addr  = {lvl_ff, node_ff};
            aw_data  = ax_rd_ff;
            aw_en    = 1'b1;
            state_in = S_DBL_RD1;
            if (last_node) begin
               node_in = NodeW'(1);
               lvl_in  = lvl_ff + LevelW'(1);
               if (lvl_ff == TopLevel) begin
                  state_in = S_IDLE;
               end
            end else begin
               node_in = node_ff + NodeW'(1);
            end
         end
         // fetch both depths, deeper node into u
         S_QA: begin
            dr_addr  = u_ff;
            state_in = S_QB;
         end
         S_QB: begin
            dr_addr  = v_ff;
            du_in    = dep_rd_ff;
            state_in = S_QC;
         end
         S_QC: begin
            if (du_ff < dep_rd_ff) begin
               u_in  = v_ff;
               v_in  = u_ff;
               du_in = dep_rd_ff;
               dv_in = du_ff;
            end else begin
               dv_in = dep_rd_ff;
            end
            lvl_in   = TopLevel;
            state_in = S_L1_RD;
         end
         // lift u to the depth of v
         S_L1_RD: begin
            ax_addr  = {lvl_ff, u_ff};
            state_in = S_L1_DEP;
         end
         S_L1_DEP: begin
            tmp_in   = ax_rd_ff;
            dr_addr  = ax_rd_ff;
            state_in = S_L1_CHK;
         end
         S_L1_CHK: begin
            if (dep_rd_ff >= dv_ff) begin
               u_in = tmp_ff;
            end
            lvl_in   = lvl_dn;
            state_in = (lvl_ff == '0) ? S_L2_RD : S_L1_RD;
         end
         // lift both while their ancestors differ
         S_L2_RD: begin
            ax_addr  = {lvl_ff, u_ff};
            ay_addr  = {lvl_ff, v_ff};
            state_in = S_L2_CHK;
         end
         S_L2_CHK: begin
            if (ax_rd_ff != ay_rd_ff) begin
               u_in = ax_rd_ff;
               v_in = ay_rd_ff;
            end
            lvl_in   = lvl_dn;
            state_in = (lvl_ff == '0) ? S_FIN_RD : S_L2_RD;
         end
         S_FIN_RD: begin
            ax_addr  = {LevelW'(0), u_ff};
            state_in = S_FIN;
         end
         // hold until the response register is free
         S_FIN: begin
            ax_addr = {LevelW'(0), u_ff};
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_anc_in   = (u_ff != v_ff) ? ax_rd_ff : u_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         count_ff     <= NodeW'(1);
         rsp_valid_ff <= 1'b0;
         chg_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         chg_ff       <= chg_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      node_ff    <= node_in;
      lvl_ff     <= lvl_in;
      u_ff       <= u_in;
      v_ff       <= v_in;
      tmp_ff     <= tmp_in;
      du_ff      <= du_in;
      dv_ff      <= dv_in;
      rsp_anc_ff <= rsp_anc_in;
   end

   // ancestor memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (aw_en) begin
         anc_mem[aw_addr] <= aw_data;
      end
      ax_rd_ff <= anc_mem[ax_addr];
      ay_rd_ff <= anc_mem[ay_addr];
   end

   // depth memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (dw_en) begin
         dep_mem[dw_addr] <= dw_data;
      end
      dep_rd_ff <= dep_mem[dr_addr];
   end

   // checks
   `BLCA_ASSERT_NOW(a_rsp_from_fin, clock, reset, $rose(rsp_valid_ff), $past(state_ff == S_FIN), "response raised outside finish")
   `BLCA_ASSERT_NOW(a_no_root_zero, clock, reset, aw_en && aw_addr[NodeW-1:0] == '0, state_ff == S_CLEAR, "write to node zero outside clear")
   `BLCA_ASSERT_NEXT(a_busy_after, clock, reset, req_fire && req_type != REQ_SET, !req_ready, "ready right after a long request")

endmodule

[bench/binary_lifting_lca_tb.sv]
// Testbench for the binary-lifting lowest-common-ancestor block
`timescale 1ns / 1ps

module binary_lifting_lca_tb;
   import blca_pkg::*;

   // Tracks the parent tree and its lifting tables and queues expected answers
   class lca_tracker;
      node_type  anc[16][1024];
      bit [10:0] dep[1024];
      int        node_total;
      node_type  expected_ancestors[$];
      int        errors;

      function new();
         wipe();
         node_total = 1;
         errors = 0;
      endfunction

      function void wipe();
         foreach (anc[j, i]) anc[j][i] = '0;
         foreach (dep[i]) dep[i] = '0;
      endfunction

      function void note_request(req_code_type kind, node_type a, node_type b);
         int        i;
         int        j;
         int        lvl;
         bit        changed;
         node_type  u;
         node_type  v;
         node_type  t;
         node_type  pa;
         node_type  pb;
         bit [10:0] d;
         case (kind)
            REQ_SET: begin
               // drop writes to node zero
               if (a != 0) anc[0][a] = b;
            end
            REQ_BUILD: begin
               for (i = 0; i < 1024; i++) dep[i] = '0;
               // first parentless node becomes the root
               for (i = 1; i <= node_total; i++) begin
                  if (anc[0][i] == 0) begin
                     anc[0][i] = node_type'(i);
                     dep[i] = 11'd1;
                     break;
                  end
               end
               // propagate depths until nothing changes
               do begin
                  changed = 1'b0;
                  for (i = 1; i <= node_total; i++) begin
                     if (dep[i] == 0) begin
                        d = dep[anc[0][i]];
                        if (d != 0) begin
                           dep[i] = (d == 11'd2047) ? d : d + 11'd1;
                           changed = 1'b1;
                        end
                     end
                  end
               end while (changed);
               // fill the doubling levels
               for (j = 1; j < 16; j++)
                  for (i = 1; i <= node_total; i++)
                     anc[j][i] = anc[j-1][anc[j-1][i]];
            end
            REQ_QUERY: begin
               u = a;
               v = b;
               if (dep[u] < dep[v]) begin
                  t = u;
                  u = v;
                  v = t;
               end
               // lift the deeper node to the other's depth
               for (lvl = 15; lvl >= 0; lvl--) begin
                  pa = anc[lvl][u];
                  if (dep[pa] >= dep[v]) u = pa;
               end
               // lift both while their ancestors differ
               for (lvl = 15; lvl >= 0; lvl--) begin
                  pa = anc[lvl][u];
                  pb = anc[lvl][v];
                  if (pa != pb) begin
                     u = pa;
                     v = pb;
                  end
               end
               if (u != v) u = anc[0][u];
               expected_ancestors.insert(expected_ancestors.size(), u);
            end
            default: wipe();
         endcase
      endfunction

      function void check_result(node_type got);
         node_type want;
         if (expected_ancestors.size() == 0) begin
            $error("ancestor: expected none, got %0d", got);
            errors++;
         end else begin
            want = expected_ancestors.pop_front();
            if (got !== want) begin
               $error("ancestor: expected %0d, got %0d", want, got);
               errors++;
            end
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_type = REQ_SET;
   node_type   req_node_a = '0;
   node_type   req_node_b = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   node_type   rsp_ancestor;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   node_type   csr_node_count = '0;

   lca_tracker sb = new();
   int         req_gap_max = 7;
   int         rsp_gap_max = 7;
   int         responses = 0;
   int         cycles = 0;

   binary_lifting_lca dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_node_a     (req_node_a),
      .req_node_b     (req_node_b),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ancestor   (rsp_ancestor),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_node_count (csr_node_count)
   );

   always #2 clock = ~clock;

   // Stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 4000000) begin
         $display("** binary_lifting_lca: FAILED **");
         $finish;
      end
   end

   // Offer one request after a random gap and hold it until accepted
   task automatic send_request(req_code_type kind, node_type a, node_type b);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_node_a <= a;
      req_node_b <= b;
      do @(posedge clock); while (!req_ready);
      sb.note_request(kind, a, b);
      @(negedge clock);
   endtask

   // Wait for every answer, let the block settle, then write the node count
   task automatic write_count(node_type value);
      req_valid <= 1'b0;
      while (sb.expected_ancestors.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      csr_valid <= 1'b1;
      csr_node_count <= value;
      do @(posedge clock); while (!csr_ready);
      sb.node_total = int'(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_query(int count);
      node_type a;
      node_type b;
      if (count > 0 && $urandom_range(0, 3) != 0) begin
         a = node_type'($urandom_range(1, count));
         b = node_type'($urandom_range(1, count));
      end else begin
         a = node_type'($urandom);
         b = node_type'($urandom);
      end
      send_request(REQ_QUERY, a, b);
   endtask

   // Set the node count, clear, grow a tree, add broken links, build, then query
   task automatic run_phase(int count, bit tall, int noise, int queries);
      int i;
      int p;
      write_count(node_type'(count));
      req_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
      rsp_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
      send_request(REQ_CLEAR, node_type'($urandom), node_type'($urandom));
      for (i = 2; i <= count; i++) begin
         p = (tall && $urandom_range(0, 3) != 0) ? i - 1 : $urandom_range(1, i - 1);
         send_request(REQ_SET, node_type'(i), node_type'(p));
      end
      for (i = 0; i < noise; i++)
         send_request(REQ_SET, node_type'($urandom), node_type'($urandom));
      send_request(REQ_BUILD, node_type'($urandom), node_type'($urandom));
      for (i = 0; i < queries; i++) random_query(count);
      // rebuild after three more links now and then
      if (count <= 64 && $urandom_range(0, 1) == 1) begin
         for (i = 0; i < 3; i++)
            send_request(REQ_SET, node_type'($urandom_range(1, count + 1)),
                         node_type'($urandom_range(0, count)));
         send_request(REQ_BUILD, '0, '0);
         for (i = 0; i < queries / 2; i++) random_query(count);
      end
   endtask

   // Accept answers after random stalls, with one long hold-off
   initial begin
      int  stall;
      bit  held;
      held = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = $urandom_range(0, rsp_gap_max);
         if (!held && responses >= 30) begin
            stall = 1500;
            held = 1'b1;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_result(rsp_ancestor);
         responses++;
         @(negedge clock);
      end
   end

   initial begin
      int k;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed requests at the reset node count
      send_request(REQ_QUERY, 10'd1, 10'd1);
      send_request(REQ_SET, 10'd0, 10'd5);
      send_request(REQ_BUILD, '0, '0);
      send_request(REQ_QUERY, 10'd1, 10'd1);
      send_request(REQ_QUERY, 10'd0, 10'd1023);
      send_request(REQ_QUERY, 10'd1023, 10'd0);
      send_request(REQ_SET, 10'd1023, 10'd1023);
      send_request(REQ_QUERY, 10'd1023, 10'd1);
      send_request(REQ_BUILD, '0, '0);
      send_request(REQ_QUERY, 10'd1023, 10'd1023);
      send_request(REQ_CLEAR, 10'd1023, 10'd1023);
      send_request(REQ_QUERY, 10'd1, 10'd0);

      // count extremes, then two small trees
      run_phase(0, 1'b0, 3, 10);
      run_phase(1, 1'b0, 2, 10);
      run_phase(4, 1'b1, 0, 10);
      run_phase(1023, 1'b0, 0, 20);
      for (k = 0; k < 2; k++)
         run_phase($urandom_range(2, 40), $urandom_range(0, 1) == 1,
                   $urandom_range(0, 4), 10);

      req_valid <= 1'b0;
      while (sb.expected_ancestors.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (sb.errors == 0) begin
         $display("** binary_lifting_lca: PASSED **");
      end else begin
         $display("** binary_lifting_lca: FAILED **");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/blca_pkg.sv
hw/rtl/binary_lifting_lca.sv
bench/binary_lifting_lca_tb.sv
